FILE: rtl/core/scm_pkg.sv
// Shared types and constants for the silence run cut marker.
// Frame and mark payloads, queue record, event and register codes.
// No dependencies.
package scm_pkg;

    typedef enum logic [1:0] {
        KIND_START     = 2'd0,
        KIND_STOP      = 2'd1,
        KIND_END_PAIRS = 2'd2,
        KIND_END_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_STEREO    = 2'd0,
        CFG_WIDE      = 2'd1,
        CFG_THRESHOLD = 2'd2,
        CFG_MIN_RUN   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic               end_of_data;
    } frame_t;

    typedef struct packed {
        kind_t       event_kind;
        logic [31:0] byte_offset;
        logic [31:0] pair_count;
        logic        is_last;
    } mark_t;

    // One classified frame: an optional cut mark and an optional end summary.
    typedef struct packed {
        logic        cut_valid;
        logic        cut_stop;
        logic        end_valid;
        logic [31:0] offset;
        logic [31:0] pairs;
    } rec_t;

    typedef struct packed {
        logic valid;
        rec_t rec;
    } push_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    // frame_index times a frame size of up to four bytes, plus one carry bit
    localparam int LAST_BYTE_W = 35;

endpackage

FILE: rtl/core/scm_front.sv
// Front part: configuration registers, quiet classification, run and cut tracking.
// Produces one record per frame that yields marks. Uses scm_pkg.
module scm_front #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                accept,
    input  scm_pkg::frame_t     frame,
    output scm_pkg::push_t      push
);

    localparam int KEEP = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
    localparam int LW   = scm_pkg::LAST_BYTE_W;

    logic               stereo_reg;
    logic               wide_reg;
    logic signed [15:0] threshold_reg;
    logic [15:0]        min_run_reg;

    logic [31:0] frame_index_reg, frame_index_next;
    logic [15:0] quiet_run_reg, quiet_run_next;
    logic        in_cut_reg, in_cut_next;
    logic [31:0] pairs_reg, pairs_next;

    logic signed [15:0] left_s, right_s;
    logic               quiet;
    logic               cut_start, cut_stop, run_short;
    logic [31:0]        pairs_after;

    logic [1:0]    size_shift;
    logic [LW-1:0] size_mask, last_byte, half_run, diff, aligned;
    logic [31:0]   offset;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stereo_reg    <= 1'b0;
            wide_reg      <= 1'b1;
            threshold_reg <= '0;
            min_run_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (scm_pkg::cfg_idx_t'(cfg_index))
                scm_pkg::CFG_STEREO:    stereo_reg    <= cfg_data[0];
                scm_pkg::CFG_WIDE:      wide_reg      <= cfg_data[0];
                scm_pkg::CFG_THRESHOLD: threshold_reg <= cfg_data;
                scm_pkg::CFG_MIN_RUN:   min_run_reg   <= cfg_data;
            endcase
        end
    end

    // 8-bit mode uses only the low byte, sign extended
    assign left_s  = wide_reg ? frame.left_sample
                              : {{8{frame.left_sample[7]}}, frame.left_sample[7:0]};
    assign right_s = wide_reg ? frame.right_sample
                              : {{8{frame.right_sample[7]}}, frame.right_sample[7:0]};
    assign quiet   = (left_s < threshold_reg) && (!stereo_reg || (right_s < threshold_reg));

    assign run_short = quiet_run_reg < min_run_reg;
    assign cut_start = quiet && !in_cut_reg && !run_short;
    assign cut_stop  = !quiet && in_cut_reg;

    // saturate the pair count at all ones
    assign pairs_after = (cut_stop && (pairs_reg != '1)) ? pairs_reg + 32'd1 : pairs_reg;

    // last byte of the frame minus min_run/2, aligned down to the frame size
    assign size_shift = {1'b0, stereo_reg} + {1'b0, wide_reg};
    assign size_mask  = (LW'(1) << size_shift) - LW'(1);
    assign last_byte  = (LW'(frame_index_reg) << size_shift) + size_mask;
    assign half_run   = LW'(min_run_reg[15:1]);
    assign diff       = last_byte - half_run;
    assign aligned    = (last_byte < half_run) ? '0 : (diff & ~size_mask);
    assign offset     = 32'(aligned[KEEP-1:0]);

    always_comb
    begin
        frame_index_next = frame_index_reg + 32'd1;
        pairs_next       = pairs_after;
        in_cut_next      = in_cut_reg;
        quiet_run_next   = '0;
        if (cut_start)
            in_cut_next = 1'b1;
        else if (cut_stop)
            in_cut_next = 1'b0;
        if (quiet)
        begin
            if (in_cut_reg)
                quiet_run_next = quiet_run_reg;
            else if (run_short)
                quiet_run_next = quiet_run_reg + 16'd1;
        end
        // end of stream: start over
        if (frame.end_of_data)
        begin
            frame_index_next = '0;
            pairs_next       = '0;
            in_cut_next      = 1'b0;
            quiet_run_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_index_reg <= '0;
            quiet_run_reg   <= '0;
            in_cut_reg      <= 1'b0;
            pairs_reg       <= '0;
        end
        else if (accept)
        begin
            frame_index_reg <= frame_index_next;
            quiet_run_reg   <= quiet_run_next;
            in_cut_reg      <= in_cut_next;
            pairs_reg       <= pairs_next;
        end
    end

    always_comb
    begin
        push.rec.cut_valid = cut_start || cut_stop;
        push.rec.cut_stop  = cut_stop;
        push.rec.end_valid = frame.end_of_data;
        push.rec.offset    = offset;
        push.rec.pairs     = pairs_after;
        push.valid         = accept && (cut_start || cut_stop || frame.end_of_data);
    end

endmodule

FILE: rtl/core/scm_queue.sv
// Short record queue between the front and back parts.
// Register file with read and write pointers. Uses scm_pkg.
module scm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  scm_pkg::push_t push,
    output logic           full,
    output logic           head_valid,
    output scm_pkg::rec_t  head,
    input  logic           pop
);

    localparam int AW = scm_pkg::QUEUE_AW;

    scm_pkg::rec_t entry_reg [scm_pkg::QUEUE_DEPTH];

    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg, count_next;

    assign full       = count_reg == (AW+1)'(scm_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
            count_next = count_reg + (AW+1)'(1);
        else if (!push.valid && pop)
            count_next = count_reg - (AW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            entry_reg[wr_ptr_reg] <= push.rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/core/scm_back.sv
// Back part: expands each queued record into one or two marks.
// Drives the output register of the mark channel. Uses scm_pkg.
module scm_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  scm_pkg::rec_t  head,
    output logic           pop,
    output logic           mark_valid,
    input  logic           mark_ready,
    output scm_pkg::mark_t mark
);

    logic           mark_valid_reg;
    scm_pkg::mark_t mark_reg, mark_next;
    logic           phase_reg, phase_next;
    logic           load;

    assign load       = head_valid && (!mark_valid_reg || mark_ready);
    assign mark_valid = mark_valid_reg;
    assign mark       = mark_reg;

    always_comb
    begin
        mark_next.pair_count = head.pairs;
        if (head.cut_valid && !phase_reg)
        begin
            mark_next.event_kind  = head.cut_stop ? scm_pkg::KIND_STOP : scm_pkg::KIND_START;
            mark_next.byte_offset = head.offset;
            mark_next.is_last     = !head.end_valid;
            // hold the record when its summary is still to come
            pop        = load && !head.end_valid;
            phase_next = load ? head.end_valid : phase_reg;
        end
        else
        begin
            mark_next.event_kind  = (head.pairs != '0) ? scm_pkg::KIND_END_PAIRS
                                                       : scm_pkg::KIND_END_NONE;
            mark_next.byte_offset = '0;
            mark_next.is_last     = 1'b1;
            pop        = load;
            phase_next = load ? 1'b0 : phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (load)
                mark_valid_reg <= 1'b1;
            else if (mark_ready)
                mark_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            mark_reg <= mark_next;
    end

endmodule

FILE: rtl/core/silence_run_cut_marker.sv
// Top level of the silence run cut marker.
// Instantiates scm_front, scm_queue and scm_back; uses scm_pkg.
//
// Takes one PCM frame per clock while the four-entry record queue has room,
// marks where quiet runs open and close a cut, and gives a summary on the
// frame flagged end_of_data. Each frame's record is written into the queue,
// then loaded into the output register. One mark leaves per cycle through
// the output register while mark_ready is high, so a frame that yields both
// a cut mark and a summary holds the queue head until both are loaded.
// Configuration writes are taken every cycle and apply from the next frame.
module silence_run_cut_marker #(
    parameter int OFFSET_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data,
    input  logic            frame_valid,
    output logic            frame_ready,
    input  scm_pkg::frame_t frame,
    output logic            mark_valid,
    input  logic            mark_ready,
    output scm_pkg::mark_t  mark
);

    scm_pkg::push_t push;
    scm_pkg::rec_t  head;
    logic           full, head_valid, pop;

    assign cfg_ready   = 1'b1;
    assign frame_ready = !full;

    scm_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (frame_valid && frame_ready),
        .frame     (frame),
        .push      (push)
    );

    scm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    scm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .mark_valid (mark_valid),
        .mark_ready (mark_ready),
        .mark       (mark)
    );

endmodule

FILE: rtl/core/scm_checker.sv
// Port-level checks for the silence run cut marker, bound to the top level.
// Uses scm_pkg.
module scm_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            mark_valid,
    input logic            mark_ready,
    input scm_pkg::mark_t  mark
);

    logic end_kind;
    assign end_kind = (mark.event_kind == scm_pkg::KIND_END_PAIRS)
                   || (mark.event_kind == scm_pkg::KIND_END_NONE);

    // a stalled mark holds
    a_mark_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mark_valid && !mark_ready |=> mark_valid && $stable(mark))
        else $error("mark changed or dropped while stalled");

    // summaries close the transfer and carry no offset
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        mark_valid && end_kind |-> mark.is_last && (mark.byte_offset == '0))
        else $error("summary mark not last or with offset");

    // summary kind agrees with the pair count
    a_end_count: assert property (@(posedge clk) disable iff (!rst_n)
        mark_valid && end_kind |->
            ((mark.event_kind == scm_pkg::KIND_END_PAIRS) == (mark.pair_count != '0)))
        else $error("summary kind disagrees with pair count");

    // a non-final mark is a cut mark and is followed by its summary
    a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
        mark_valid && mark_ready && !mark.is_last |=> mark_valid && end_kind)
        else $error("cut mark without following summary");

endmodule

bind silence_run_cut_marker scm_checker u_scm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .mark_valid (mark_valid),
    .mark_ready (mark_ready),
    .mark       (mark)
);

FILE: sim/tb_silence_run_cut_marker.sv
// Self-checking bench for silence_run_cut_marker: frames go in through a queue-fed
// driver, marks are checked against a cycle-free predictor of the cut logic.
// Depends on scm_pkg and the silence_run_cut_marker RTL.
module tb_silence_run_cut_marker;
    timeunit 1ns;
    timeprecision 1ps;

    logic            clk;
    logic            rst_n;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [1:0]      cfg_index = '0;
    logic [15:0]     cfg_data  = '0;
    logic            frame_valid = 1'b0;
    logic            frame_ready;
    scm_pkg::frame_t frame = '0;
    logic            mark_valid;
    logic            mark_ready = 1'b0;
    scm_pkg::mark_t  mark;

    silence_run_cut_marker dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .mark_valid  (mark_valid),
        .mark_ready  (mark_ready),
        .mark        (mark)
    );

    // Register copies, updated on each config transfer
    logic               stereo_mode     = 1'b0;
    logic               wide_samples    = 1'b1;
    logic signed [15:0] quiet_threshold = '0;
    logic [15:0]        min_run         = '0;

    // Detector state
    logic [31:0] frame_index  = '0;
    logic [15:0] quiet_run    = '0;
    logic        in_cut       = 1'b0;
    logic [31:0] pairs_closed = '0;

    scm_pkg::frame_t pending_frames[$];
    scm_pkg::mark_t  expected_marks[$];
    logic   frame_went = 1'b0;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     hold_request   = 0;
    int     hold_left      = 0;
    int     failures       = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic level_is_quiet(logic [15:0] raw);
        logic signed [15:0] lv;
        lv = wide_samples ? raw : {{8{raw[7]}}, raw[7:0]};
        return lv < quiet_threshold;
    endfunction

    function automatic logic [31:0] mark_offset();
        logic [63:0] fsize;
        logic [63:0] last_byte;
        logic [63:0] half;
        logic [63:0] v;
        fsize     = (stereo_mode ? 64'd2 : 64'd1) * (wide_samples ? 64'd2 : 64'd1);
        last_byte = {32'd0, frame_index} * fsize + fsize - 64'd1;
        half      = {48'd0, min_run >> 1};
        if (last_byte < half)
            return '0;
        v = (last_byte - half) & ~(fsize - 64'd1);
        return v[31:0];
    endfunction

    task automatic predict_marks(input scm_pkg::frame_t f);
        scm_pkg::mark_t marks_out[2];
        int    n;
        logic  quiet;
        n     = 0;
        quiet = level_is_quiet(f.left_sample)
                && (!stereo_mode || level_is_quiet(f.right_sample));
        if (quiet)
        begin
            if (!in_cut)
            begin
                if (quiet_run < min_run)
                    quiet_run = quiet_run + 16'd1;
                else
                begin
                    marks_out[n] = '{scm_pkg::KIND_START, mark_offset(), pairs_closed, 1'b0};
                    n++;
                    in_cut    = 1'b1;
                    quiet_run = '0;
                end
            end
        end
        else
        begin
            if (in_cut)
            begin
                marks_out[n].byte_offset = mark_offset();
                in_cut = 1'b0;
                if (pairs_closed != 32'hFFFF_FFFF)
                    pairs_closed = pairs_closed + 32'd1;
                marks_out[n].event_kind = scm_pkg::KIND_STOP;
                marks_out[n].pair_count = pairs_closed;
                marks_out[n].is_last    = 1'b0;
                n++;
            end
            quiet_run = '0;
        end
        frame_index = frame_index + 32'd1;
        if (f.end_of_data)
        begin
            marks_out[n].event_kind  = (pairs_closed != 0) ? scm_pkg::KIND_END_PAIRS
                                                           : scm_pkg::KIND_END_NONE;
            marks_out[n].byte_offset = '0;
            marks_out[n].pair_count  = pairs_closed;
            marks_out[n].is_last     = 1'b0;
            n++;
            frame_index  = '0;
            quiet_run    = '0;
            in_cut       = 1'b0;
            pairs_closed = '0;
        end
        for (int i = 0; i < n; i++)
        begin
            marks_out[i].is_last = (i == n - 1);
            expected_marks.insert(expected_marks.size(), marks_out[i]);
        end
    endtask

    // Monitor: track config and frame transfers, check every mark transfer
    always @(posedge clk)
    begin
        scm_pkg::mark_t want;
        if (rst_n)
        begin
            frame_went <= frame_valid && frame_ready;
            if (cfg_valid && cfg_ready)
            begin
                case (scm_pkg::cfg_idx_t'(cfg_index))
                    scm_pkg::CFG_STEREO:    stereo_mode     = cfg_data[0];
                    scm_pkg::CFG_WIDE:      wide_samples    = cfg_data[0];
                    scm_pkg::CFG_THRESHOLD: quiet_threshold = cfg_data;
                    scm_pkg::CFG_MIN_RUN:   min_run         = cfg_data;
                    default: ;
                endcase
            end
            if (frame_valid && frame_ready)
                predict_marks(frame);
            if (mark_valid && mark_ready)
            begin
                if (expected_marks.size() == 0)
                begin
                    $error("unexpected mark: kind %0d offset %0d pairs %0d",
                           mark.event_kind, mark.byte_offset, mark.pair_count);
                    failures++;
                end
                else
                begin
                    want = expected_marks.pop_front();
                    if (mark.event_kind !== want.event_kind)
                    begin
                        $error("event_kind: expected %0d, got %0d",
                               want.event_kind, mark.event_kind);
                        failures++;
                    end
                    if (mark.byte_offset !== want.byte_offset)
                    begin
                        $error("byte_offset: expected %0d, got %0d",
                               want.byte_offset, mark.byte_offset);
                        failures++;
                    end
                    if (mark.pair_count !== want.pair_count)
                    begin
                        $error("pair_count: expected %0d, got %0d",
                               want.pair_count, mark.pair_count);
                        failures++;
                    end
                    if (mark.is_last !== want.is_last)
                    begin
                        $error("is_last: expected %0d, got %0d", want.is_last, mark.is_last);
                        failures++;
                    end
                end
            end
        end
    end

    // Driver: hold the frame until its transfer, then advance or idle
    always @(negedge clk)
    begin
        if (rst_n && (!frame_valid || frame_went))
        begin
            if (pending_frames.size() != 0
                && !(send_idle_pct > 0 && $urandom_range(99) < send_idle_pct))
            begin
                frame       <= pending_frames.pop_front();
                frame_valid <= 1'b1;
            end
            else
                frame_valid <= 1'b0;
        end
    end

    // Receiver: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (!rst_n)
            mark_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            mark_ready <= 1'b0;
            hold_left--;
        end
        else
            mark_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    // Called at a falling edge; leaves cfg_valid high for a following write
    task automatic write_reg(input scm_pkg::cfg_idx_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic stereo, input logic wide,
                                  input logic [15:0] thr, input logic [15:0] run_len);
        write_reg(scm_pkg::CFG_STEREO, {15'd0, stereo});
        write_reg(scm_pkg::CFG_WIDE, {15'd0, wide});
        write_reg(scm_pkg::CFG_THRESHOLD, thr);
        write_reg(scm_pkg::CFG_MIN_RUN, run_len);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_frame(input logic [15:0] l, input logic [15:0] r, input logic eod);
        scm_pkg::frame_t f;
        f.left_sample  = l;
        f.right_sample = r;
        f.end_of_data  = eod;
        pending_frames.insert(pending_frames.size(), f);
    endtask

    // Wait until every frame is taken and every mark has left, then settle
    task automatic drain_stream();
        while (pending_frames.size() != 0 || frame_valid)
            @(posedge clk);
        @(negedge clk);
        while (expected_marks.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic logic [15:0] make_sample(logic want_quiet);
        logic [15:0] raw;
        int          near;
        raw = 16'($urandom);
        for (int tries = 0; tries < 16; tries++)
        begin
            raw = 16'($urandom);
            if ($urandom_range(1) == 1)
            begin
                near = int'(quiet_threshold) + int'($urandom_range(0, 127)) - 64;
                if (wide_samples)
                    raw = 16'(near);
                else
                    raw[7:0] = 8'(near);
            end
            if (level_is_quiet(raw) == want_quiet)
                return raw;
        end
        return raw;
    endfunction

    task automatic push_shaped(input logic want_quiet, input logic eod);
        logic [15:0] l;
        logic [15:0] r;
        if (!stereo_mode || want_quiet)
        begin
            l = make_sample(want_quiet);
            r = stereo_mode ? make_sample(1'b1) : 16'($urandom);
        end
        else if ($urandom_range(1) == 1)
        begin
            l = make_sample(1'b0);
            r = 16'($urandom);
        end
        else
        begin
            l = 16'($urandom);
            r = make_sample(1'b0);
        end
        push_frame(l, r, eod);
    endtask

    initial
    begin
        int          queued;
        int          bursts;
        int          qlen;
        logic [15:0] thr_val;
        logic [15:0] run_val;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: mono, 16-bit, threshold 0, no run needed
        push_frame(16'h8000, 16'h0000, 1'b0);   // opens a cut at once
        push_frame(16'hFFFF, 16'h7FFF, 1'b0);   // right ignored in mono
        push_frame(16'h0000, 16'h8000, 1'b0);   // equal to threshold: loud, closes
        push_frame(16'h7FFF, 16'h0000, 1'b1);   // end with one pair
        push_frame(16'hFFFB, 16'h0000, 1'b1);   // start then end, open cut dropped
        push_frame(16'h0064, 16'h0000, 1'b1);   // end, none found
        push_frame(16'h8000, 16'h0000, 1'b0);   // stay in a cut across the settings change
        drain_stream();

        // Stereo, 8-bit: upper bits ignored, low byte sign extended
        apply_settings(1'b1, 1'b0, 16'd16, 16'd3);
        push_frame(16'h0005, 16'h0020, 1'b0);   // closes the carried cut
        repeat (4) push_frame(16'h7F05, 16'h0090, 1'b0);
        push_frame(16'h0005, 16'h0020, 1'b0);   // right loud closes
        push_frame(16'h0020, 16'h0005, 1'b0);
        push_frame(16'h8000, 16'hFF80, 1'b0);
        push_frame(16'h00FF, 16'h0010, 1'b1);
        drain_stream();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                2:       thr_val = 16'h8000;
                5:       thr_val = 16'h7FFF;
                4:       thr_val = 16'($urandom);
                default: thr_val = 16'(int'($urandom_range(0, 200)) - 100);
            endcase
            case (phase)
                3:       run_val = 16'hFFFF;
                6:       run_val = 16'd0;
                7:       run_val = 16'($urandom_range(20, 40));
                default: run_val = 16'($urandom_range(0, 8));
            endcase
            apply_settings(phase[0], phase[1] ^ phase[2], thr_val, run_val);
            send_idle_pct  = (phase % 4 == 1) ? 45 : (phase % 4 == 3) ? 22 : 0;
            recv_stall_pct = (phase % 4 == 2) ? 45 : (phase % 4 == 3) ? 22 : 0;
            if (phase == 0)
                hold_request = 300;   // let the block back up while frames keep coming

            queued = 0;
            while (queued < 210)
            begin
                if ($urandom_range(99) < 6)
                begin
                    push_frame(16'($urandom), 16'($urandom), $urandom_range(3) == 0);
                    queued++;
                end
                else
                begin
                    bursts = $urandom_range(1, 5);
                    for (int b = 0; b < bursts; b++)
                    begin
                        qlen = (min_run <= 40) ? int'(min_run) + $urandom_range(0, 3)
                                               : $urandom_range(1, 12);
                        for (int k = 0; k < qlen; k++)
                            push_shaped(1'b1, 1'b0);
                        for (int k = $urandom_range(0, 3); k > 0; k--)
                            push_shaped(1'b0, 1'b0);
                        queued += qlen + 2;
                    end
                    push_shaped($urandom_range(1), $urandom_range(9) < 8);
                    queued++;
                end
            end
            drain_stream();
        end

        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
